[design/ffra_pkg.sv]
// ffra_pkg: shared types, codes and helpers of the first-fit range allocator
// used by the range cells, the top level and the port checker
// no dependencies
package ffra_pkg;

    localparam int unsigned MAX_RANGES_DEF = 16;
    localparam logic [31:0] POOL_RESET     = 32'd8 * 32'd1024 * 32'd1024;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FREED = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_INIT   = 3'd1,
        OP_ROT    = 3'd2,
        OP_WRITE  = 3'd3,
        OP_REMOVE = 3'd4,
        OP_INSERT = 3'd5
    } cell_op_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } entry_t;

    typedef struct packed {
        cell_op_t    op;
        logic [31:0] start;
        logic [31:0] len;
    } cell_cmd_t;

    typedef struct packed {
        logic        func;
        logic [31:0] req_size;
        logic [31:0] req_offset;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] result_offset;
        logic [31:0] bytes_in_use;
    } result_t;

    // saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

[design/first_fit_range_allocator_top.sv]
// first_fit_range_allocator_top: sequencer plus a ring of range cells
// depends on ffra_pkg and ffra_cell
//
// usage
//   request channel: drive req and pulse start while busy is low; the request
//     is taken at that edge and busy stays high until the answer is out
//   result channel: done is high for exactly one cycle with result; the
//     receiver cannot stall, so it must take the result in that cycle
//   config channel: cfg_valid/cfg_ready write the pool size; cfg_ready is high
//     while idle and no request is being started, and a write reseeds the
//     table with one free range [0, pool size) and clears the byte count
//   reset: the table holds one range [0, 8 MiB), byte count zero, block idle
// timing
//   the ring rotates one slot per cycle past a head comparator, and a pass
//     visits every slot; a second pass places a range in order
//   (split on allocate, insert or moved range on free)
//   of the one-pass requests, the slowest is a free that joins both neighbors
//   busy is low in the cycle done is high, so a new request can be taken then
module first_fit_range_allocator_top
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_RANGES = MAX_RANGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int unsigned KW = $clog2(MAX_RANGES);
    localparam int unsigned CW = $clog2(MAX_RANGES + 1);
    localparam logic [KW-1:0] LAST_K = KW'(MAX_RANGES - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RANGES);

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_SCAN    = 10'b00_0000_0010,
        S_DECIDE  = 10'b00_0000_0100,
        S_MERGE   = 10'b00_0000_1000,
        S_WRITE   = 10'b00_0001_0000,
        S_REMOVE  = 10'b00_0010_0000,
        S_PSCAN   = 10'b00_0100_0000,
        S_PDECIDE = 10'b00_1000_0000,
        S_DONE    = 10'b01_0000_0000,
        S_SPARE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // ring of cells, slot 0 is the head seen by the comparators
    entry_t        cell_q [MAX_RANGES];
    cell_cmd_t     cmd;
    logic [KW-1:0] cmd_idx;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            ffra_cell #(
                .MAX_RANGES (MAX_RANGES),
                .IDX        (gi)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .cmd_idx    (cmd_idx),
                .prev_entry (cell_q[(gi + MAX_RANGES - 1) % MAX_RANGES]),
                .next_entry (cell_q[(gi + 1) % MAX_RANGES]),
                .entry      (cell_q[gi])
            );
        end
    endgenerate

    // request and bookkeeping registers
    logic [KW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   used_reg, used_next;
    logic          func_reg, func_next;
    logic [31:0]   size_reg, size_next;
    logic [31:0]   off_reg, off_next;
    logic [32:0]   upper_reg, upper_next;

    // first-pass search results
    logic          found_reg, found_next;
    logic [KW-1:0] idx_reg, idx_next;
    logic [31:0]   hit_start_reg, hit_start_next;
    logic [31:0]   hit_len_reg, hit_len_next;
    logic          done1_reg, done1_next;
    logic          inside_reg, inside_next;
    logic          joined_reg, joined_next;
    logic [KW-1:0] low_idx_reg, low_idx_next;
    logic [31:0]   low_len_reg, low_len_next;

    // pending edit
    logic          do_remove_reg, do_remove_next;
    logic          do_place_reg, do_place_next;
    logic [31:0]   pend_start_reg, pend_start_next;
    logic [31:0]   pend_len_reg, pend_len_next;

    // place search results
    logic          pfound_reg, pfound_next;
    logic          peq_reg, peq_next;
    logic [KW-1:0] pj_reg, pj_next;

    status_t       status_reg, status_next;
    logic [31:0]   roff_reg, roff_next;

    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    // head comparisons
    entry_t        head;
    logic [32:0]   head_end;
    logic          in_range;
    logic [KW-1:0] place_idx;
    logic [31:0]   used_upd;

    assign head     = cell_q[0];
    assign head_end = {1'b0, head.start} + {1'b0, head.len};
    assign in_range = (CW'(k_reg) < count_reg);
    assign place_idx = pfound_reg ? pj_reg : count_reg[KW-1:0];

    always_comb
    begin
        if (status_reg != ST_OK)
        begin
            used_upd = used_reg;
        end
        else if (func_reg == FUNC_FREE)
        begin
            used_upd = used_reg - size_reg;
        end
        else
        begin
            used_upd = used_reg + size_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        used_next       = used_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        off_next        = off_reg;
        upper_next      = upper_reg;
        found_next      = found_reg;
        idx_next        = idx_reg;
        hit_start_next  = hit_start_reg;
        hit_len_next    = hit_len_reg;
        done1_next      = done1_reg;
        inside_next     = inside_reg;
        joined_next     = joined_reg;
        low_idx_next    = low_idx_reg;
        low_len_next    = low_len_reg;
        do_remove_next  = do_remove_reg;
        do_place_next   = do_place_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        pfound_next     = pfound_reg;
        peq_next        = peq_reg;
        pj_next         = pj_reg;
        status_next     = status_reg;
        roff_next       = roff_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        cmd.op          = OP_NOP;
        cmd.start       = pend_start_reg;
        cmd.len         = pend_len_reg;
        cmd_idx         = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next      = req.func;
                    size_next      = req.req_size;
                    off_next       = req.req_offset;
                    upper_next     = {1'b0, req.req_offset} + {1'b0, req.req_size};
                    k_next         = '0;
                    found_next     = 1'b0;
                    done1_next     = 1'b0;
                    inside_next    = 1'b0;
                    joined_next    = 1'b0;
                    pfound_next    = 1'b0;
                    peq_next       = 1'b0;
                    do_remove_next = 1'b0;
                    do_place_next  = 1'b0;
                    roff_next      = '0;
                    status_next    = ST_OK;
                    state_next     = S_SCAN;
                end
                else if (cfg_valid)
                begin
                    // reseed the table
                    cmd.op     = OP_INIT;
                    cmd.len    = cfg_data;
                    count_next = CW'(1);
                    used_next  = '0;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_ROT;
                if (in_range)
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        // first range long enough
                        if (!found_reg && head.len >= size_reg)
                        begin
                            found_next     = 1'b1;
                            idx_next       = k_reg;
                            hit_start_next = head.start;
                            hit_len_next   = head.len;
                        end
                    end
                    else
                    begin
                        // containment and lower neighbor, stops at first hit
                        if (!done1_reg)
                        begin
                            if ({1'b0, head.start} <= {1'b0, off_reg} && head_end >= upper_reg)
                            begin
                                inside_next = 1'b1;
                                done1_next  = 1'b1;
                            end
                            else if (head_end == {1'b0, off_reg})
                            begin
                                joined_next  = 1'b1;
                                low_idx_next = k_reg;
                                low_len_next = head.len;
                                done1_next   = 1'b1;
                            end
                        end
                        // upper neighbor
                        if (!found_reg && {1'b0, head.start} == upper_reg)
                        begin
                            found_next   = 1'b1;
                            idx_next     = k_reg;
                            hit_len_next = head.len;
                        end
                    end
                end
                if (k_reg == LAST_K)
                begin
                    k_next     = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    k_next = KW'(k_reg + 1'b1);
                end
            end
            S_DECIDE:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // take the front, leave the tail as a new range
                        roff_next       = hit_start_reg;
                        do_remove_next  = 1'b1;
                        do_place_next   = (hit_len_reg != size_reg);
                        pend_start_next = hit_start_reg + size_reg;
                        pend_len_next   = hit_len_reg - size_reg;
                        state_next      = S_REMOVE;
                    end
                end
                else if (inside_reg)
                begin
                    status_next = ST_FREED;
                    state_next  = S_DONE;
                end
                else if (joined_reg)
                begin
                    pend_len_next = sat_add(low_len_reg, size_reg);
                    if (found_reg && idx_reg != low_idx_reg)
                    begin
                        // bridge both neighbors
                        do_remove_next = 1'b1;
                        state_next     = S_MERGE;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
                else if (found_reg)
                begin
                    // upper neighbor moves down to the freed start
                    pend_len_next   = sat_add(hit_len_reg, size_reg);
                    pend_start_next = off_reg;
                    do_remove_next  = 1'b1;
                    do_place_next   = 1'b1;
                    state_next      = S_REMOVE;
                end
                else
                begin
                    pend_start_next = off_reg;
                    pend_len_next   = size_reg;
                    do_place_next   = 1'b1;
                    state_next      = S_PSCAN;
                end
            end
            S_MERGE:
            begin
                pend_len_next = sat_add(pend_len_reg, hit_len_reg);
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.op     = OP_WRITE;
                cmd_idx    = low_idx_reg;
                state_next = do_remove_reg ? S_REMOVE : S_DONE;
            end
            S_REMOVE:
            begin
                cmd.op     = OP_REMOVE;
                cmd_idx    = idx_reg;
                count_next = CW'(count_reg - 1'b1);
                state_next = do_place_reg ? S_PSCAN : S_DONE;
            end
            S_PSCAN:
            begin
                cmd.op = OP_ROT;
                // first slot whose start is not below the new start
                if (in_range && !pfound_reg && head.start >= pend_start_reg)
                begin
                    pfound_next = 1'b1;
                    pj_next     = k_reg;
                    peq_next    = (head.start == pend_start_reg);
                end
                if (k_reg == LAST_K)
                begin
                    k_next     = '0;
                    state_next = S_PDECIDE;
                end
                else
                begin
                    k_next = KW'(k_reg + 1'b1);
                end
            end
            S_PDECIDE:
            begin
                cmd_idx = place_idx;
                if (pfound_reg && peq_reg)
                begin
                    // same start: overwrite the length
                    cmd.op = OP_WRITE;
                end
                else if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op     = OP_INSERT;
                    count_next = CW'(count_reg + 1'b1);
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                used_next                 = used_upd;
                done_next                 = 1'b1;
                result_next.status        = status_reg;
                result_next.result_offset =
                    (func_reg == FUNC_ALLOC && status_reg == ST_OK) ? roff_reg : '0;
                result_next.bytes_in_use  = used_upd;
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            count_reg <= CW'(1);
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        size_reg       <= size_next;
        off_reg        <= off_next;
        upper_reg      <= upper_next;
        found_reg      <= found_next;
        idx_reg        <= idx_next;
        hit_start_reg  <= hit_start_next;
        hit_len_reg    <= hit_len_next;
        done1_reg      <= done1_next;
        inside_reg     <= inside_next;
        joined_reg     <= joined_next;
        low_idx_reg    <= low_idx_next;
        low_len_reg    <= low_len_next;
        do_remove_reg  <= do_remove_next;
        do_place_reg   <= do_place_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
        pfound_reg     <= pfound_next;
        peq_reg        <= peq_next;
        pj_reg         <= pj_next;
        status_reg     <= status_next;
        roff_reg       <= roff_next;
        result_reg     <= result_next;
    end

    assign busy      = (state_reg != S_IDLE);
    // a request being started wins over a config write
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done      = done_reg;
    assign result    = result_reg;

endmodule

[design/ffra_cell.sv]
// ffra_cell: one slot of the free-range table, part of a ring of cells
// depends on ffra_pkg
module ffra_cell
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
    parameter int unsigned IDX        = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_cmd_t                     cmd,
    input  logic [$clog2(MAX_RANGES)-1:0] cmd_idx,
    input  entry_t                        prev_entry,
    input  entry_t                        next_entry,
    output entry_t                        entry
);

    localparam int unsigned IDX_W = $clog2(MAX_RANGES);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic IS_HEAD = (IDX == 0);
    localparam logic IS_LAST = (IDX == MAX_RANGES - 1);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_INIT:
            begin
                entry_next.start = '0;
                entry_next.len   = IS_HEAD ? cmd.len : '0;
            end
            OP_ROT:
            begin
                entry_next = next_entry;
            end
            OP_WRITE:
            begin
                if (cmd_idx == MY_IDX)
                begin
                    entry_next.len = cmd.len;
                end
            end
            OP_REMOVE:
            begin
                // close the gap: everything from the removed slot moves down
                if (cmd_idx <= MY_IDX)
                begin
                    entry_next = IS_LAST ? entry_t'('0) : next_entry;
                end
            end
            OP_INSERT:
            begin
                // open a gap at the insert slot
                if (cmd_idx == MY_IDX)
                begin
                    entry_next.start = cmd.start;
                    entry_next.len   = cmd.len;
                end
                else if (cmd_idx < MY_IDX)
                begin
                    entry_next = prev_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.start <= '0;
            entry_reg.len   <= IS_HEAD ? POOL_RESET : '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

[design/ffra_checker.sv]
// ffra_checker: port-level checks of the first-fit range allocator
// depends on ffra_pkg; bound to first_fit_range_allocator_top
module ffra_checker
    import ffra_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result,
    input logic    cfg_ready
);

    // a taken request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // each answer closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // a failed request carries no offset
    a_fail_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.result_offset == 32'd0))
        else $error("nonzero offset on a failed request");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (!busy && !start))
        else $error("config ready while busy or starting");

endmodule

bind first_fit_range_allocator_top ffra_checker u_ffra_checker (.*);
